// ===== rtl/ttar_pkg.sv =====
// Shared types, constants and helpers for the teletext adapter register block.
// No dependencies; imported by ttar_ram users and teletext_adapter_registers.
`default_nettype none

package ttar_pkg;

    // row store geometry
    localparam int ROW_COUNT   = 16;
    localparam int ROW_BYTES   = 64;
    localparam int STORE_DEPTH = ROW_COUNT * ROW_BYTES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ROW_W       = 4;
    localparam int COL_W       = 6;
    localparam int CFG_DATA_W  = 4;

    // packet and timing constants
    localparam logic [7:0]  PKT_LEAD       = 8'h27;
    localparam logic [7:0]  ABSENT_READ    = 8'hFF;
    localparam logic [5:0]  PKT_LAST_POS   = 6'd41;
    localparam logic [15:0] IVL_FSYNC_ODD  = 16'd640;
    localparam logic [15:0] IVL_FSYNC_EVEN = 16'd580;
    localparam logic [15:0] IVL_DEW        = 16'd2176;
    localparam logic [15:0] IVL_FIELD_EVEN = 16'd37184;
    localparam logic [15:0] IVL_FIELD_ODD  = 16'd37244;

    typedef enum logic [1:0] {
        REQ_READ   = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_FIELD  = 2'd2,
        REQ_PACKET = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        REG_CTRL  = 2'd0,
        REG_ROW   = 2'd1,
        REG_DATA  = 2'd2,
        REG_CLEAR = 2'd3
    } t_reg;

    typedef enum logic {
        CFG_PRESENT = 1'b0,
        CFG_LINK    = 1'b1
    } t_cfg;

    typedef enum logic [1:0] {
        PH_FIELD = 2'd0,
        PH_FSYNC = 2'd1,
        PH_DEW   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_READ  = 2'd2,
        ST_PKT2  = 2'd3
    } t_state;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [1:0]       reg_addr;
        logic [7:0]       write_data;
        logic [ROW_W-1:0] packet_row;
        logic [COL_W-1:0] packet_pos;
        logic [7:0]       packet_byte;
    } t_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        irq;
        logic        dew_active;
        logic [15:0] next_interval;
        logic [1:0]  channel_select;
    } t_result;

    // flat store address of a row and column
    function automatic logic [ADDR_W-1:0] store_addr(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        return ADDR_W'(int'(row) * ROW_BYTES + int'(col));
    endfunction

    function automatic logic row_ok(input logic [ROW_W-1:0] row);
        return int'(row) < ROW_COUNT;
    endfunction

    function automatic logic col_ok(input logic [COL_W-1:0] col);
        return int'(col) < ROW_BYTES;
    endfunction

    // column step with wrap after the last column
    function automatic logic [COL_W-1:0] col_next(input logic [COL_W-1:0] col);
        logic [COL_W-1:0] nxt;
        nxt = col + 1'b1;
        if (int'(nxt) >= ROW_BYTES) begin
            nxt = '0;
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ttar_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module ttar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write into the array, registered read returns the old data on a write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/teletext_adapter_registers.sv =====
// Teletext adapter register block: host bus registers, field timing, row store.
// Depends on ttar_pkg and ttar_ram.
`default_nettype none

// Usage
// An item (bus read, bus write, field event or packet byte) on i_item is taken
// at a rising edge with start high and busy low. Each item gives one result
// beat on o_result, flagged by o_strobe for exactly one cycle; the receiver
// takes it at the end of that cycle and cannot hold it off.
// The result beat is registered and comes in the cycle after the item is taken,
// except a read of the data port, whose beat passes first through the
// registered read of the row store RAM and then the result register.
// Throughput: one item per cycle; a data port read and an accepted packet start
// raise busy while the single RAM port does either the read or the second
// write (column 1) of the packet start, in ST_READ or ST_PKT2.
// Reset: control state returns to its reset values and a clearing pass writes
// zero into all 1024 row store entries, one per cycle; busy is high for the whole
// pass. Configuration writes on i_cfg_we are taken at any time, also during the
// clearing pass.
module teletext_adapter_registers
    import ttar_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_item                 i_item,
    output logic                       o_strobe,
    output t_result                    o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic       r_present;
    logic [3:0] r_link;

    // control state
    t_state           r_state,    n_state;
    logic [ADDR_W-1:0] r_clr_cnt, n_clr_cnt;
    logic             r_fsync,    n_fsync;
    logic             r_dor,      n_dor;
    logic             r_int,      n_int;
    logic             r_irq_en,   n_irq_en;
    logic             r_rx_en,    n_rx_en;
    logic [1:0]       r_chan,     n_chan;
    logic [ROW_W-1:0] r_row,      n_row;
    logic [COL_W-1:0] r_col,      n_col;
    t_phase           r_phase,    n_phase;
    logic             r_parity,   n_parity;
    logic             r_pkt_acc,  n_pkt_acc;
    logic             r_irq,      n_irq;
    logic             r_valid,    n_valid;

    // payload of the held result and of the second packet-start write
    t_result           r_out,       n_out;
    logic              r_pkt2_en,   n_pkt2_en;
    logic [ADDR_W-1:0] r_pkt2_addr, n_pkt2_addr;
    logic [7:0]        r_pkt2_data, n_pkt2_data;

    // row store port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    // item decode scratch
    logic [7:0]       rdata;
    logic [15:0]      interval;
    logic             read_mem;
    logic             acc;
    logic [COL_W-1:0] pkt_col;

    ttar_ram #(
        .WIDTH(8),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_valid;
    assign o_result = r_out;

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= 1'b1;
            r_link    <= 4'hF;
        end else if (i_cfg_we) begin
            case (t_cfg'(i_cfg_idx))
                CFG_PRESENT: r_present <= i_cfg_data[0];
                CFG_LINK:    r_link    <= i_cfg_data;
                default:     r_link    <= r_link;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
            r_fsync   <= 1'b0;
            r_dor     <= 1'b0;
            r_int     <= 1'b0;
            r_irq_en  <= 1'b0;
            r_rx_en   <= 1'b0;
            r_chan    <= '0;
            r_row     <= '0;
            r_col     <= '0;
            r_phase   <= PH_FIELD;
            r_parity  <= 1'b0;
            r_pkt_acc <= 1'b0;
            r_irq     <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_fsync   <= n_fsync;
            r_dor     <= n_dor;
            r_int     <= n_int;
            r_irq_en  <= n_irq_en;
            r_rx_en   <= n_rx_en;
            r_chan    <= n_chan;
            r_row     <= n_row;
            r_col     <= n_col;
            r_phase   <= n_phase;
            r_parity  <= n_parity;
            r_pkt_acc <= n_pkt_acc;
            r_irq     <= n_irq;
            r_valid   <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out       <= n_out;
        r_pkt2_en   <= n_pkt2_en;
        r_pkt2_addr <= n_pkt2_addr;
        r_pkt2_data <= n_pkt2_data;
    end

    // next state, store access and result
    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_fsync     = r_fsync;
        n_dor       = r_dor;
        n_int       = r_int;
        n_irq_en    = r_irq_en;
        n_rx_en     = r_rx_en;
        n_chan      = r_chan;
        n_row       = r_row;
        n_col       = r_col;
        n_phase     = r_phase;
        n_parity    = r_parity;
        n_pkt_acc   = r_pkt_acc;
        n_irq       = r_irq;
        n_valid     = 1'b0;
        n_out       = r_out;
        n_pkt2_en   = r_pkt2_en;
        n_pkt2_addr = r_pkt2_addr;
        n_pkt2_data = r_pkt2_data;
        ram_we      = 1'b0;
        ram_addr    = r_clr_cnt;
        ram_wdata   = '0;
        rdata       = '0;
        interval    = '0;
        read_mem    = 1'b0;
        acc         = 1'b0;
        pkt_col     = i_item.packet_pos + 1'b1;

        case (r_state)
            // zero the row store after reset
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr_cnt;
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == ADDR_W'(STORE_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end

            // data port read: RAM data is here now
            ST_READ: begin
                n_out.read_data = ram_rdata;
                n_valid         = 1'b1;
                n_state         = ST_IDLE;
            end

            // second write of a packet start (column 1)
            ST_PKT2: begin
                ram_we    = r_pkt2_en;
                ram_addr  = r_pkt2_addr;
                ram_wdata = r_pkt2_data;
                n_state   = ST_IDLE;
            end

            ST_IDLE: begin
                if (start) begin
                    if (!r_present) begin
                        if (t_req'(i_item.req_type) == REQ_READ) begin
                            rdata = ABSENT_READ;
                        end
                    end else begin
                        case (t_req'(i_item.req_type))
                            REQ_READ: begin
                                case (t_reg'(i_item.reg_addr))
                                    REG_CTRL: begin
                                        rdata = {r_int, r_dor, (r_phase == PH_DEW),
                                                 r_fsync, r_link};
                                    end
                                    REG_DATA: begin
                                        if (row_ok(r_row) && col_ok(r_col)) begin
                                            ram_addr = store_addr(r_row, r_col);
                                            read_mem = 1'b1;
                                        end
                                        n_col = col_next(r_col);
                                    end
                                    REG_CLEAR: begin
                                        n_fsync = 1'b0;
                                        n_dor   = 1'b0;
                                        n_int   = 1'b0;
                                        n_irq   = 1'b0;
                                    end
                                    default: rdata = '0;
                                endcase
                            end

                            REQ_WRITE: begin
                                case (t_reg'(i_item.reg_addr))
                                    REG_CTRL: begin
                                        n_irq_en = i_item.write_data[3];
                                        n_irq    = i_item.write_data[3] & r_int;
                                        n_rx_en  = i_item.write_data[2];
                                        n_chan   = i_item.write_data[1:0];
                                    end
                                    REG_ROW: begin
                                        n_row = i_item.write_data[ROW_W-1:0];
                                        n_col = '0;
                                    end
                                    REG_DATA: begin
                                        if (row_ok(r_row) && col_ok(r_col)) begin
                                            ram_we    = 1'b1;
                                            ram_addr  = store_addr(r_row, r_col);
                                            ram_wdata = i_item.write_data;
                                        end
                                        n_col = col_next(r_col);
                                    end
                                    default: begin
                                        n_fsync = 1'b0;
                                        n_dor   = 1'b0;
                                        n_int   = 1'b0;
                                        n_irq   = 1'b0;
                                    end
                                endcase
                            end

                            // field phase step
                            REQ_FIELD: begin
                                case (r_phase)
                                    PH_FSYNC: begin
                                        n_dor    = r_int;
                                        interval = IVL_DEW;
                                        n_phase  = PH_DEW;
                                        n_parity = ~r_parity;
                                        n_row    = '0;
                                        n_col    = '0;
                                    end
                                    PH_DEW: begin
                                        n_int    = 1'b1;
                                        interval = r_parity ? IVL_FIELD_ODD
                                                            : IVL_FIELD_EVEN;
                                        n_phase  = PH_FIELD;
                                        if (r_irq_en) begin
                                            n_irq = 1'b1;
                                        end
                                    end
                                    default: begin
                                        n_phase  = PH_FSYNC;
                                        n_fsync  = 1'b1;
                                        interval = r_parity ? IVL_FSYNC_ODD
                                                            : IVL_FSYNC_EVEN;
                                    end
                                endcase
                            end

                            // packet byte
                            default: begin
                                if (i_item.packet_pos == '0) begin
                                    acc       = r_rx_en && (i_item.packet_byte != '0);
                                    n_pkt_acc = acc;
                                    if (acc && row_ok(i_item.packet_row)) begin
                                        ram_we      = 1'b1;
                                        ram_addr    = store_addr(i_item.packet_row, '0);
                                        ram_wdata   = PKT_LEAD;
                                        n_pkt2_en   = col_ok(COL_W'(1));
                                        n_pkt2_addr = store_addr(i_item.packet_row,
                                                                 COL_W'(1));
                                        n_pkt2_data = i_item.packet_byte;
                                        n_state     = ST_PKT2;
                                    end
                                end else if (i_item.packet_pos <= PKT_LAST_POS
                                             && r_pkt_acc
                                             && row_ok(i_item.packet_row)
                                             && col_ok(pkt_col)) begin
                                    ram_we    = 1'b1;
                                    ram_addr  = store_addr(i_item.packet_row, pkt_col);
                                    ram_wdata = i_item.packet_byte;
                                end
                            end
                        endcase
                    end

                    // result beat, held back through ST_READ for a RAM read
                    n_out.read_data      = rdata;
                    n_out.irq            = n_irq;
                    n_out.dew_active     = (n_phase == PH_DEW);
                    n_out.next_interval  = interval;
                    n_out.channel_select = n_chan;
                    if (read_mem) begin
                        n_state = ST_READ;
                    end else begin
                        n_valid = 1'b1;
                    end
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire
